// ----- hw/rtl/imu_complementary_tilt_filter_defines.svh -----
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_defines.svh
// Assertion macros shared by the tilt filter RTL.
// ----------------------------------------------------------------------------
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_DEFINES_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_DEFINES_SVH

// Plain property, checked on every clock edge out of reset
`define IMU_CTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Next-cycle implication, checked out of reset
`define IMU_CTF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/imu_ctf_pkg.sv -----
// ----------------------------------------------------------------------------
// imu_ctf_pkg
// Types, register indexes and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package imu_ctf_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_WEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z     = 3'd4;

    // Square root and CORDIC widths
    localparam int SQ_IN_W   = 48;
    localparam int SQ_OUT_W  = 24;
    localparam int SQ_STEPS  = 24;
    localparam int CORD_XW   = 28;
    localparam int TBL_LEN   = 24;
    localparam int TBL_FRAC  = 24;
    localparam int TIDX_W    = 5;

    // Shared multiplier operand widths
    localparam int MUL_AW = 18;
    localparam int MUL_BW = 34;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Divider divisor width and constant divisors
    localparam int DIV_DW = 18;
    localparam logic [DIV_DW-1:0] DIV_GYRO = 18'd262000;
    localparam logic [DIV_DW-1:0] DIV_TEMP = 18'd340;

    // Reciprocals of the constant divisors, floor(2^RCP_SH / divisor)
    localparam int RCP_W  = 26;
    localparam int RCP_SH = 34;
    localparam logic [RCP_W-1:0] RCP_GYRO = 26'd65572;
    localparam logic [RCP_W-1:0] RCP_TEMP = 26'd50529027;

    // atan(2^-i) in degrees, Q8.24
    localparam logic signed [31:0] ATAN_TBL [0:TBL_LEN-1] = '{
        32'sd754974720, 32'sd445687602, 32'sd235489088, 32'sd119537938,
        32'sd60000934,  32'sd30029717,  32'sd15018523,  32'sd7509720,
        32'sd3754917,   32'sd1877466,   32'sd938734,    32'sd469367,
        32'sd234684,    32'sd117342,    32'sd58671,     32'sd29335,
        32'sd14668,     32'sd7334,      32'sd3667,      32'sd1833,
        32'sd917,       32'sd458,       32'sd229,       32'sd115
    };

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ1,
        S_SQ2,
        S_SQ3,
        S_SQRT,
        S_CORD,
        S_GMUL,
        S_GDIV,
        S_GWAIT,
        S_TDIV,
        S_TWAIT,
        S_B1,
        S_B2,
        S_B3,
        S_B4,
        S_B5,
        S_SEED,
        S_OUT
    } t_state;

endpackage

// ----- hw/rtl/imu_complementary_tilt_filter.sv -----
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter
// Complementary tilt filter for a six-axis IMU sample stream.
// ----------------------------------------------------------------------------
// One sample is worked at a time by a sequencer around one multiplier, a
// bit-serial square root, an iterative CORDIC and a reciprocal-multiply
// divider for the constant divisors. For each sample the sequencer runs two
// square roots and CORDIC runs, then three gyro steps and the temperature
// division, each division worked in digits of 16 quotient bits, then the
// blend and the output. o_ready is high only while the sequencer is idle;
// a finished result waits in the output register, and the next result is
// held until that one is taken. Configuration writes take effect at once
// and belong in idle time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "imu_complementary_tilt_filter_defines.svh"

module imu_complementary_tilt_filter #(
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [imu_ctf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [imu_ctf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [15:0]                 i_accel_x,
    input  logic signed [15:0]                 i_accel_y,
    input  logic signed [15:0]                 i_accel_z,
    input  logic signed [15:0]                 i_temp_raw,
    input  logic signed [15:0]                 i_rate_x,
    input  logic signed [15:0]                 i_rate_y,
    input  logic signed [15:0]                 i_rate_z,
    input  logic [15:0]                        i_elapsed_ms,
    input  logic                               i_seed,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [31:0]                 o_angle_x,
    output logic signed [31:0]                 o_angle_y,
    output logic signed [31:0]                 o_angle_z,
    output logic signed [31:0]                 o_gyro_angle_x,
    output logic signed [31:0]                 o_gyro_angle_y,
    output logic signed [23:0]                 o_tilt_accel_x,
    output logic signed [23:0]                 o_tilt_accel_y,
    output logic signed [16:0]                 o_temperature
);
    import imu_ctf_pkg::*;

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int DW    = F + 36;
    localparam int IW    = F + 18;
    localparam int PW    = ((F + 19) > 33 ? (F + 19) : 33) + 1;
    localparam int AW    = PW + 20;
    localparam int SW    = (IW > 32 ? IW : 32) + 1;
    localparam int STEPS = CORDIC_STEPS < TBL_LEN ? CORDIC_STEPS : TBL_LEN;
    localparam logic signed [31:0] LIM = 32'(90 << F);

    // configuration
    logic [16:0]        r_gw, r_aw;
    logic signed [15:0] r_off [0:2];

    // sample and working state
    t_state             r_state, n_state;
    logic signed [15:0] r_ax, r_ay, r_az, r_temp;
    logic signed [15:0] r_rate [0:2];
    logic [15:0]        r_ms;
    logic               r_seed;
    logic               r_axis;
    logic [1:0]         r_gax;
    logic signed [MUL_PW-1:0] r_prod;
    logic signed [AW-1:0]     r_acc;
    logic signed [PW-1:0]     r_p;
    logic signed [31:0]       r_tilt [0:1];
    logic signed [IW-1:0]     r_inc [0:1];
    logic signed [16:0]       r_tq;
    logic signed [31:0]       r_filt [0:1];
    logic signed [31:0]       r_int [0:2];

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_o_ax, r_o_ay, r_o_az, r_o_gx, r_o_gy;
    logic signed [23:0] r_o_tx, r_o_ty;
    logic signed [16:0] r_o_tq;

    // shared multiplier
    logic signed [MUL_AW-1:0] m_a;
    logic signed [MUL_BW-1:0] m_b;

    // units
    logic                   sq_start, sq_done, cd_start, cd_done, dv_start, dv_done;
    logic [SQ_IN_W-1:0]     sq_in;
    logic [SQ_OUT_W-1:0]    sq_root;
    logic signed [15:0]     num;
    logic signed [31:0]     cd_z, z_sh, z_clamp;
    logic signed [DW-1:0]   dv_n;
    logic [DIV_DW-1:0]      dv_d;
    logic [RCP_W-1:0]       dv_m;
    logic signed [DW:0]     dv_q;
    logic signed [16:0]     dgyro;
    logic signed [IW-1:0]   inc_q;
    logic signed [SW-1:0]   int_sum;
    logic signed [AW-1:0]   blend_sum;
    logic [31:0]            sq_sum;

    function automatic logic signed [31:0] f_sat_int(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi, lo;
        hi = {{(SW-32){1'b0}}, 32'h7fff_ffff};
        lo = {{(SW-32){1'b1}}, 32'h8000_0000};
        if (v > hi)      f_sat_int = 32'sh7fff_ffff;
        else if (v < lo) f_sat_int = 32'sh8000_0000;
        else             f_sat_int = v[31:0];
    endfunction

    function automatic logic signed [31:0] f_sat_acc(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi, lo;
        hi = {{(AW-32){1'b0}}, 32'h7fff_ffff};
        lo = {{(AW-32){1'b1}}, 32'h8000_0000};
        if (v > hi)      f_sat_acc = 32'sh7fff_ffff;
        else if (v < lo) f_sat_acc = 32'sh8000_0000;
        else             f_sat_acc = v[31:0];
    endfunction

    function automatic logic signed [23:0] f_sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607)       f_sat24 = 24'sh7f_ffff;
        else if (v < -32'sd8388608) f_sat24 = 24'sh80_0000;
        else                        f_sat24 = v[23:0];
    endfunction

    imu_ctf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_in),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    imu_ctf_cordic #(.STEPS(STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cd_start),
        .i_x0    (sq_root),
        .i_y0    ({num, 8'h00}),
        .o_done  (cd_done),
        .o_z     (cd_z)
    );

    imu_ctf_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dv_start),
        .i_dividend (dv_n),
        .i_divisor  (dv_d),
        .i_recip    (dv_m),
        .o_done     (dv_done),
        .o_quotient (dv_q)
    );

    // datapath helpers
    assign num      = r_axis ? r_ax : r_ay;
    assign sq_sum   = r_acc[31:0] + r_prod[31:0];
    assign sq_in    = {sq_sum, 16'h0000};
    assign sq_start = (r_state == S_SQ3);
    assign cd_start = (r_state == S_SQRT) && sq_done;
    assign z_sh     = cd_z >>> (TBL_FRAC - F);
    assign z_clamp  = (num == 16'sd0) ? 32'sd0 :
                      (z_sh > LIM) ? LIM : (z_sh < -LIM) ? -LIM : z_sh;
    assign dgyro    = 17'(r_rate[r_gax]) - 17'(r_off[r_gax]);
    assign dv_start = (r_state == S_GDIV) || (r_state == S_TDIV);
    assign dv_n     = (r_state == S_TDIV)
                      ? DW'((17'(r_temp) + 17'sd12412)) <<< 8
                      : (DW'(r_prod) <<< (F + 2)) + DW'(131000);
    assign dv_d     = (r_state == S_TDIV) ? DIV_TEMP : DIV_GYRO;
    assign dv_m     = (r_state == S_TDIV) ? RCP_TEMP : RCP_GYRO;
    assign inc_q    = dv_q[IW-1:0];
    assign int_sum  = SW'(r_int[r_gax]) + SW'(inc_q);
    assign blend_sum = r_acc + AW'(r_prod) + AW'(32768);

    // multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            S_SQ1: begin
                m_a = MUL_AW'(r_az);
                m_b = MUL_BW'(r_az);
            end
            S_SQ2: begin
                m_a = MUL_AW'(r_axis ? r_ay : r_ax);
                m_b = MUL_BW'(r_axis ? r_ay : r_ax);
            end
            S_GMUL: begin
                m_a = MUL_AW'(dgyro);
                m_b = MUL_BW'($signed({1'b0, r_ms}));
            end
            S_B2: begin
                m_a = $signed({1'b0, r_gw});
                m_b = MUL_BW'($signed(r_p[PW-1:24]));
            end
            S_B3: begin
                m_a = $signed({1'b0, r_gw});
                m_b = MUL_BW'($signed({1'b0, r_p[23:0]}));
            end
            S_B4: begin
                m_a = $signed({1'b0, r_aw});
                m_b = MUL_BW'(r_tilt[r_axis]);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw     <= 17'd64225;
            r_aw     <= 17'd1311;
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_off[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GYRO_WEIGHT:  r_gw     <= i_cfg_data;
                CFG_ACCEL_WEIGHT: r_aw     <= i_cfg_data;
                CFG_OFFSET_X:     r_off[0] <= i_cfg_data[15:0];
                CFG_OFFSET_Y:     r_off[1] <= i_cfg_data[15:0];
                CFG_OFFSET_Z:     r_off[2] <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = S_SQ1;
            end
            S_SQ1: n_state = S_SQ2;
            S_SQ2: n_state = S_SQ3;
            S_SQ3: n_state = S_SQRT;
            S_SQRT: if (sq_done) n_state = S_CORD;
            S_CORD: if (cd_done) n_state = r_axis ? S_GMUL : S_SQ1;
            S_GMUL: n_state = S_GDIV;
            S_GDIV: n_state = S_GWAIT;
            S_GWAIT: if (dv_done) n_state = (r_gax == 2'd2) ? S_TDIV : S_GMUL;
            S_TDIV: n_state = S_TWAIT;
            S_TWAIT: if (dv_done) n_state = S_B1;
            S_B1: n_state = S_B2;
            S_B2: n_state = S_B3;
            S_B3: n_state = S_B4;
            S_B4: n_state = S_B5;
            S_B5: n_state = r_axis ? S_SEED : S_B1;
            S_SEED: n_state = S_OUT;
            S_OUT: if (!r_out_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis    <= 1'b0;
            r_gax     <= '0;
            r_filt[0] <= '0;
            r_filt[1] <= '0;
            r_int[0]  <= '0;
            r_int[1]  <= '0;
            r_int[2]  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_axis <= 1'b0;
                    r_gax  <= '0;
                end
                S_CORD: if (cd_done) begin
                    r_tilt[r_axis] <= r_axis ? -z_clamp : z_clamp;
                    r_axis         <= ~r_axis;
                end
                S_GWAIT: if (dv_done) begin
                    if (r_gax != 2'd2) r_inc[r_gax[0]] <= inc_q;
                    r_int[r_gax] <= f_sat_int(int_sum);
                    r_gax        <= r_gax + 2'd1;
                end
                S_B5: begin
                    r_filt[r_axis] <= f_sat_acc(blend_sum >>> 16);
                    r_axis         <= ~r_axis;
                end
                S_SEED: if (r_seed) begin
                    r_int[0]  <= '0;
                    r_int[1]  <= '0;
                    r_filt[0] <= r_tilt[0];
                    r_filt[1] <= r_tilt[1];
                end
                default: ;
            endcase
        end
    end

    // payload-only registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_ax      <= i_accel_x;
            r_ay      <= i_accel_y;
            r_az      <= i_accel_z;
            r_temp    <= i_temp_raw;
            r_rate[0] <= i_rate_x;
            r_rate[1] <= i_rate_y;
            r_rate[2] <= i_rate_z;
            r_ms      <= i_elapsed_ms;
            r_seed    <= i_seed;
        end
        if (r_state == S_SQ2) r_acc <= AW'(r_prod);
        if (r_state == S_B3)  r_acc <= AW'(r_prod) <<< 24;
        if (r_state == S_B4)  r_acc <= r_acc + AW'(r_prod);
        if (r_state == S_B1)  r_p   <= PW'(r_filt[r_axis]) + PW'(r_inc[r_axis]);
        if (r_state == S_TWAIT && dv_done) r_tq <= dv_q[16:0];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_out_valid || i_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_out_valid || i_ready)) begin
            r_o_ax <= r_filt[0];
            r_o_ay <= r_filt[1];
            r_o_az <= r_int[2];
            r_o_gx <= r_int[0];
            r_o_gy <= r_int[1];
            r_o_tx <= f_sat24(r_tilt[0]);
            r_o_ty <= f_sat24(r_tilt[1]);
            r_o_tq <= r_tq;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_angle_x      = r_o_ax;
    assign o_angle_y      = r_o_ay;
    assign o_angle_z      = r_o_az;
    assign o_gyro_angle_x = r_o_gx;
    assign o_gyro_angle_y = r_o_gy;
    assign o_tilt_accel_x = r_o_tx;
    assign o_tilt_accel_y = r_o_ty;
    assign o_temperature  = r_o_tq;

    // assertions
    `IMU_CTF_ASSERT_IMP(a_accept_busy, i_valid && o_ready, r_state != S_IDLE, "accept did not start sequencer")
    `IMU_CTF_ASSERT_IMP(a_out_wait, r_state == S_OUT && r_out_valid && !i_ready, r_state == S_OUT, "result overwrote a stalled transaction")
    `IMU_CTF_ASSERT_IMP(a_seed_clear, r_state == S_SEED && r_seed, r_int[0] == 32'sd0 && r_int[1] == 32'sd0, "seed did not clear gyro integrals")
    `IMU_CTF_ASSERT(a_out_from_seq, $rose(r_out_valid) |-> $past(r_state) == S_OUT, "output valid rose outside output state")

endmodule

// ----- hw/rtl/imu_ctf_sqrt.sv -----
// ----------------------------------------------------------------------------
// imu_ctf_sqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_ctf_sqrt (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [imu_ctf_pkg::SQ_IN_W-1:0]  i_value,
    output logic                             o_done,
    output logic [imu_ctf_pkg::SQ_OUT_W-1:0] o_root
);
    import imu_ctf_pkg::*;

    logic [SQ_IN_W-1:0] r_v, r_r, r_bit;
    logic [TIDX_W-1:0]  r_cnt;
    logic               r_busy, r_done;
    logic [SQ_IN_W-1:0] trial;

    assign trial = r_r + r_bit;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == TIDX_W'(SQ_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: one compare and subtract per step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_value;
            r_r   <= '0;
            r_bit <= SQ_IN_W'(1) << (SQ_IN_W - 2);
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[SQ_OUT_W-1:0];

endmodule

// ----- hw/rtl/imu_ctf_cordic.sv -----
// ----------------------------------------------------------------------------
// imu_ctf_cordic
// Iterative CORDIC in vectoring mode, one rotation per cycle, Q8.24 degrees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_ctf_cordic #(
    parameter int STEPS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [imu_ctf_pkg::SQ_OUT_W-1:0] i_x0,
    input  logic signed [23:0]               i_y0,
    output logic                             o_done,
    output logic signed [31:0]               o_z
);
    import imu_ctf_pkg::*;

    logic signed [CORD_XW-1:0] r_x, r_y, xs, ys;
    logic signed [31:0]        r_z;
    logic [TIDX_W-1:0]         r_i;
    logic                      r_busy, r_done;

    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == TIDX_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // rotate toward the x axis
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORD_XW'($signed({1'b0, i_x0}));
            r_y <= CORD_XW'(i_y0);
            r_z <= '0;
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ATAN_TBL[r_i];
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ATAN_TBL[r_i];
            end
        end
    end

    assign o_done = r_done;
    assign o_z    = r_z;

endmodule

// ----- hw/rtl/imu_ctf_div.sv -----
// ----------------------------------------------------------------------------
// imu_ctf_div
// Division by a constant through its reciprocal, in digits of 16 quotient
// bits, floor rounding for signed dividends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imu_ctf_div #(
    parameter int DW = 52
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [DW-1:0]           i_dividend,
    input  logic [imu_ctf_pkg::DIV_DW-1:0] i_divisor,
    input  logic [imu_ctf_pkg::RCP_W-1:0]  i_recip,
    output logic                           o_done,
    output logic signed [DW:0]             o_quotient
);
    import imu_ctf_pkg::*;

    localparam int LB  = 16;                  // quotient bits per digit
    localparam int NL  = (DW + LB - 1) / LB;  // digits
    localparam int MW  = NL * LB;
    localparam int CW  = $clog2(NL);
    localparam int VW  = DIV_DW + LB;         // partial dividend, below 2^RCP_SH
    localparam int PMW = VW + RCP_W;

    logic [MW-1:0]     r_mag, r_q;
    logic [DIV_DW-1:0] r_d, r_rem;
    logic [RCP_W-1:0]  r_m;
    logic              r_neg, r_busy, r_done;
    logic [CW-1:0]     r_cnt;
    logic [1:0]        r_ph;
    logic [PMW-1:0]    r_pm;
    logic [VW-1:0]     r_pd;
    logic [VW-1:0]     part, diff, qd_prod;
    logic [PMW-1:0]    pm_prod;
    logic [LB-1:0]     q_est;
    logic [DW-1:0]     mag0;

    // floor of a negative quotient: divide |n| + d - 1 and negate
    assign mag0  = i_dividend[DW-1] ? DW'(-i_dividend) + DW'(i_divisor) - DW'(1)
                                    : DW'(i_dividend);

    // digit estimate is exact or one low; one compare and subtract fixes it
    assign part    = {r_rem, r_mag[MW-1 -: LB]};
    assign pm_prod = PMW'(part) * PMW'(r_m);
    assign q_est   = r_pm[RCP_SH +: LB];
    assign qd_prod = VW'(q_est) * VW'(r_d);
    assign diff    = part - r_pd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_ph   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_ph   <= '0;
            end else if (r_busy) begin
                if (r_ph == 2'd2) begin
                    r_ph  <= '0;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(NL - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_ph <= r_ph + 2'd1;
                end
            end
        end
    end

    // per digit: reciprocal product, back-multiply, correct
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= MW'(mag0);
            r_q   <= '0;
            r_rem <= '0;
            r_d   <= i_divisor;
            r_m   <= i_recip;
            r_neg <= i_dividend[DW-1];
        end else if (r_busy) begin
            case (r_ph)
                2'd0: r_pm <= pm_prod;
                2'd1: r_pd <= qd_prod;
                2'd2: begin
                    r_mag <= r_mag << LB;
                    if (diff >= VW'(r_d)) begin
                        r_rem <= DIV_DW'(diff - VW'(r_d));
                        r_q   <= {r_q[MW-LB-1:0], q_est + LB'(1)};
                    end else begin
                        r_rem <= diff[DIV_DW-1:0];
                        r_q   <= {r_q[MW-LB-1:0], q_est};
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_q[DW-1:0]}) : $signed({1'b0, r_q[DW-1:0]});

endmodule
